[hw/rtl/linear_blend_skinning_assert.svh]
// assertion macros for the skinning block
`ifndef LINEAR_BLEND_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LBS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define LBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/lbs_pkg.sv]
// package: constants and types for the skinning block
package lbs_pkg;
   localparam int MAX_JOINTS      = 256;
   localparam int FRAC_BITS       = 16;
   localparam int ELEMS_PER_JOINT = 12;
   localparam int SLOTS           = 4;
   localparam int DEPTH           = MAX_JOINTS * ELEMS_PER_JOINT;
   localparam int ADDR_W          = $clog2(DEPTH);
   localparam int JOINT_W         = $clog2(MAX_JOINTS);
   localparam int ACC_W           = 44;   // 32-bit value times 8-bit weight, 4 terms
   localparam int ROW_W           = 50;   // three floored 64-bit products plus offset
   localparam int TOT_W           = 10;
   localparam logic FUNC_WRITE    = 1'b0;
   localparam logic FUNC_SKIN     = 1'b1;

   // status from the divider to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage

[hw/rtl/lbs_ram.sv]
// generic single-port ram with registered read
module lbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // old data on a same-address write, read data registered
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

[hw/rtl/lbs_div.sv]
// restoring divider: signed dividend by unsigned divisor, one bit a cycle
module lbs_div
   import lbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ACC_W-1:0]  dividend,
   input  logic [TOT_W-1:0]         divisor,
   output logic signed [ACC_W-1:0]  quotient,
   output div_stat_type             stat
);
   localparam int CNT_W = $clog2(ACC_W + 1);

   logic [ACC_W-1:0] q_ff, q_in;
   logic [TOT_W:0]   r_ff, r_in;
   logic [TOT_W-1:0] d_ff, d_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [TOT_W:0]   trial;
   logic [TOT_W+1:0] diff;

   // one quotient bit per cycle
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[TOT_W-1:0], q_ff[ACC_W-1]};
      diff = {1'b0, trial} - {2'b00, d_ff};
      if (start) begin
         neg_in  = dividend[ACC_W-1];
         q_in    = dividend[ACC_W-1] ? ACC_W'(-dividend) : dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = CNT_W'(ACC_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[TOT_W+1]) begin
            r_in = diff[TOT_W:0];
            q_in = {q_ff[ACC_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[ACC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = neg_ff ? -$signed(q_ff) : $signed(q_ff);
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule

[hw/rtl/linear_blend_skinning.sv]
// top level: sequencer, shared multiply-accumulate and palette memory
//
//  channel | direction | handshake
//  req_    | in        | req_valid / req_stall
//  rsp_    | out       | rsp_valid / rsp_stall
//  csr_    | in        | csr_write_enable, no wait
//
// a palette write goes straight to memory on accept; a vertex runs 4 slot checks,
// 12 element reads per contributing joint through the one 32x32 multiplier, and
// 3 divides, or none and a pass-through of the position when no joint contributes.
// reset is synchronous; the palette is not cleared.
// a held result stalls the block until rsp_stall drops; the next beat is
// taken the cycle after the result beat.
module linear_blend_skinning
   import lbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [7:0]         req_palette_joint,
   input  logic [3:0]         req_palette_elem,
   input  logic signed [31:0] req_palette_value,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_joint_ids,
   input  logic [31:0]        req_joint_weights,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_passed_through,
   input  logic               csr_write_enable,
   input  logic [8:0]         csr_write_data
);
`include "linear_blend_skinning_assert.svh"

   localparam logic [2:0] ST_IDLE = 3'd0, ST_SLOT = 3'd1, ST_READ = 3'd2,
                          ST_MAC  = 3'd3, ST_DIV = 3'd4, ST_WAIT = 3'd5,
                          ST_OUT  = 3'd6;

   logic [8:0]              count_ff;
   logic [2:0]              st_ff, st_in;
   logic signed [31:0]      p_ff [3];
   logic [31:0]             ids_ff, wts_ff;
   logic [1:0]              slot_ff, slot_in;
   logic [3:0]              elem_ff, elem_in;
   logic                    rvalid_ff, rvalid_in;
   logic [3:0]              relem_ff, relem_in;
   logic signed [ROW_W-1:0] q_ff, q_in;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [ACC_W-1:0] acc_in [3];
   logic [TOT_W-1:0]        tot_ff, tot_in;
   logic [1:0]              row_ff, row_in;
   logic signed [31:0]      o_ff [3];
   logic                    pt_ff, pt_in, ov_ff, ov_in;
   logic signed [63:0]      prod_ff;
   logic                    pv_ff;
   logic [3:0]              pelem_ff;

   logic                    accept, ram_we, div_start;
   logic [ADDR_W-1:0]       ram_addr;
   logic [31:0]             ram_rdata;
   logic [7:0]              cur_j, cur_w;
   logic signed [31:0]      mul_b;
   logic signed [ACC_W-1:0] div_q;
   logic signed [31:0]      q_sat;
   div_stat_type            dstat;
   logic [1:0]              relem_col;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE);
   assign cur_j     = ids_ff[8*slot_ff +: 8];
   assign cur_w     = wts_ff[8*slot_ff +: 8];
   assign relem_col = relem_ff[1:0];

   // palette memory, one port shared by writes and reads
   assign ram_we = accept && (req_func == FUNC_WRITE)
                   && (req_palette_elem < 4'(ELEMS_PER_JOINT));
   always_comb begin
      if (st_ff == ST_IDLE)
         ram_addr = ADDR_W'(req_palette_joint) * ADDR_W'(ELEMS_PER_JOINT)
                    + ADDR_W'(req_palette_elem);
      else
         ram_addr = ADDR_W'(cur_j) * ADDR_W'(ELEMS_PER_JOINT) + ADDR_W'(elem_ff);
   end

   lbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr),
      .wdata(req_palette_value), .rdata(ram_rdata));

   // shared multiplier, registered product; the offset column passes through times one
   assign mul_b = (relem_col == 2'd3) ? 32'sd1 : p_ff[relem_col];
   always_ff @(posedge clock) begin
      prod_ff  <= $signed(ram_rdata) * mul_b;
      pelem_ff <= relem_ff;
      pv_ff    <= rvalid_ff && !reset;
   end

   // saturate the row sum
   always_comb begin
      if (q_ff[ROW_W-1:31] == '0 || q_ff[ROW_W-1:31] == '1) q_sat = q_ff[31:0];
      else if (q_ff[ROW_W-1])                              q_sat = 32'sh80000000;
      else                                                 q_sat = 32'sh7fffffff;
   end

   assign div_start = (st_ff == ST_DIV) && (tot_ff != '0);
   lbs_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(acc_ff[row_ff]), .divisor(tot_ff),
      .quotient(div_q), .stat(dstat));

   // sequencer
   always_comb begin
      st_in = st_ff; slot_in = slot_ff; elem_in = elem_ff;
      rvalid_in = 1'b0; relem_in = elem_ff; q_in = q_ff;
      for (int i = 0; i < 3; i++) acc_in[i] = acc_ff[i];
      tot_in = tot_ff; row_in = row_ff; pt_in = pt_ff; ov_in = ov_ff;
      // accumulate finished products
      if (pv_ff) begin
         if (pelem_ff[1:0] == 2'd3)
            q_in = q_ff + ROW_W'($signed(prod_ff[31:0]));
         else
            q_in = q_ff + ROW_W'(prod_ff >>> FRAC_BITS);
         if (pelem_ff[1:0] == 2'd3 && pelem_ff != 4'd3 && pelem_ff != 4'd7
             && pelem_ff != 4'd11) q_in = q_ff;
      end
      case (st_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_SKIN) begin
               st_in = ST_SLOT; slot_in = '0;
               for (int i = 0; i < 3; i++) acc_in[i] = '0;
               tot_in = '0;
            end
         end
         ST_SLOT: begin
            if (cur_w != 8'd0 && {1'b0, cur_j} < count_ff) begin
               st_in = ST_READ; elem_in = '0; q_in = '0;
            end else if (slot_ff == 2'(SLOTS - 1)) begin
               st_in = ST_DIV; row_in = '0;
            end else slot_in = slot_ff + 1'b1;
         end
         ST_READ: begin
            rvalid_in = 1'b1; relem_in = elem_ff;
            if (elem_ff[1:0] == 2'd3) st_in = ST_MAC;
            elem_in = elem_ff + 1'b1;
         end
         ST_MAC: begin
            // drain: ram read, multiply, accumulate
            if (!rvalid_ff && !pv_ff) begin
               acc_in[elem_ff[3:2] - 1'b1] = acc_ff[elem_ff[3:2] - 1'b1]
                  + ACC_W'(q_sat) * $signed({1'b0, cur_w});
               q_in = '0;
               if (elem_ff == 4'(ELEMS_PER_JOINT)) begin
                  tot_in = tot_ff + TOT_W'(cur_w);
                  if (slot_ff == 2'(SLOTS - 1)) begin
                     st_in = ST_DIV; row_in = '0;
                  end else begin
                     st_in = ST_SLOT; slot_in = slot_ff + 1'b1;
                  end
               end else st_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (tot_ff == '0) begin
               pt_in = 1'b1; st_in = ST_OUT; ov_in = 1'b1;
            end else begin
               pt_in = 1'b0; st_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (dstat.done) begin
               if (row_ff == 2'd2) begin
                  st_in = ST_OUT; ov_in = 1'b1;
               end else begin
                  row_in = row_ff + 1'b1; st_in = ST_DIV;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               ov_in = 1'b0; st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (accept && req_func == FUNC_SKIN) begin
         p_ff[0] <= req_pos_x; p_ff[1] <= req_pos_y; p_ff[2] <= req_pos_z;
         ids_ff <= req_joint_ids; wts_ff <= req_joint_weights;
      end
      if (st_ff == ST_DIV && tot_ff == '0)
         for (int i = 0; i < 3; i++) o_ff[i] <= p_ff[i];
      if (st_ff == ST_WAIT && dstat.done) o_ff[row_ff] <= div_q[31:0];
      slot_ff <= slot_in; elem_ff <= elem_in; relem_ff <= relem_in;
      q_ff <= q_in; tot_ff <= tot_in; row_ff <= row_in; pt_ff <= pt_in;
      for (int i = 0; i < 3; i++) acc_ff[i] <= acc_in[i];
      if (reset) begin
         st_ff <= ST_IDLE; rvalid_ff <= 1'b0; ov_ff <= 1'b0; count_ff <= '0;
      end else begin
         st_ff <= st_in; rvalid_ff <= rvalid_in; ov_ff <= ov_in;
         if (csr_write_enable) count_ff <= csr_write_data;
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_out_x          = o_ff[0];
   assign rsp_out_y          = o_ff[1];
   assign rsp_out_z          = o_ff[2];
   assign rsp_passed_through = pt_ff;

   // checks
   `LBS_ASSERT_IMP(a_valid_in_out, rsp_valid, st_ff == ST_OUT)
   `LBS_ASSERT_IMP(a_no_div_when_idle, dstat.busy, st_ff == ST_WAIT)
   `LBS_ASSERT_NEXT(a_hold_result, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_x))
endmodule

[tb/sv/tb_linear_blend_skinning.sv]
// testbench for the linear blend skinning block
`timescale 1ns / 1ps
module tb_linear_blend_skinning;
   import lbs_pkg::*;

   // joints whose palette entries are all loaded before any vertex
   localparam int LOADED_JOINTS = 24;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               passed;
   } skin_pos_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_func;
   logic [7:0]         req_palette_joint;
   logic [3:0]         req_palette_elem;
   logic signed [31:0] req_palette_value;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic signed [31:0] req_pos_z;
   logic [31:0]        req_joint_ids;
   logic [31:0]        req_joint_weights;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic               rsp_passed_through;
   logic               csr_write_enable;
   logic [8:0]         csr_write_data;

   // predictor state
   logic signed [31:0] palette_copy [DEPTH];
   logic [8:0]         joint_count;
   skin_pos_type       expected_pos [$];

   int  error_count;
   int  cycle_count;
   int  vertex_count;
   int  pass_count;
   int  write_count;
   bit  rx_idle_en;
   bit  tx_idle_en;
   int  hold_cycles;

   linear_blend_skinning uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_palette_joint(req_palette_joint), .req_palette_elem(req_palette_elem),
      .req_palette_value(req_palette_value),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_joint_ids(req_joint_ids), .req_joint_weights(req_joint_weights),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_passed_through(rsp_passed_through),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle limit: the run ends in failure if it overruns the limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // floored product of a matrix element and a coordinate
   function automatic longint floor_product(logic signed [31:0] m, logic signed [31:0] p);
      longint prod;
      prod = longint'(m) * longint'(p);
      return prod >>> FRAC_BITS;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // blended position of one vertex
   function automatic skin_pos_type blend_vertex(logic signed [31:0] px, logic signed [31:0] py,
                                                 logic signed [31:0] pz, logic [31:0] ids,
                                                 logic [31:0] wts);
      skin_pos_type res;
      longint acc [3];
      longint total;
      longint q;
      logic signed [31:0] p [3];
      int lim, j, w, base;
      p[0] = px; p[1] = py; p[2] = pz;
      acc[0] = 0; acc[1] = 0; acc[2] = 0;
      total = 0;
      lim = (joint_count > MAX_JOINTS) ? MAX_JOINTS : joint_count;
      for (int k = 0; k < SLOTS; k++) begin
         j = ids[8*k +: 8];
         w = wts[8*k +: 8];
         if (w != 0 && j < lim) begin
            base = j * ELEMS_PER_JOINT;
            for (int r = 0; r < 3; r++) begin
               q = longint'(palette_copy[base + r*4 + 3]);
               for (int c = 0; c < 3; c++)
                  q += floor_product(palette_copy[base + r*4 + c], p[c]);
               acc[r] += clamp32(q) * w;
            end
            total += w;
         end
      end
      if (total == 0) begin
         res.x = px; res.y = py; res.z = pz; res.passed = 1'b1;
      end else begin
         res.x = 32'(clamp32(acc[0] / total));
         res.y = 32'(clamp32(acc[1] / total));
         res.z = 32'(clamp32(acc[2] / total));
         res.passed = 1'b0;
      end
      return res;
   endfunction

   // result checker
   always @(posedge clock) begin
      skin_pos_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pos.size() == 0) begin
            $error("result beat with no vertex outstanding");
            error_count++;
         end else begin
            want = expected_pos.pop_front();
            if (rsp_out_x !== want.x) begin
               $error("out_x expected %0d actual %0d", want.x, rsp_out_x);
               error_count++;
            end
            if (rsp_out_y !== want.y) begin
               $error("out_y expected %0d actual %0d", want.y, rsp_out_y);
               error_count++;
            end
            if (rsp_out_z !== want.z) begin
               $error("out_z expected %0d actual %0d", want.z, rsp_out_z);
               error_count++;
            end
            if (rsp_passed_through !== want.passed) begin
               $error("passed_through expected %0d actual %0d", want.passed,
                      rsp_passed_through);
               error_count++;
            end
         end
      end
   end

   // receiver stall: random bursts, or a long forced hold
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // send one beat and wait for its acceptance
   task automatic send_beat(logic func, logic [7:0] joint, logic [3:0] elem,
                            logic signed [31:0] value, logic signed [31:0] px,
                            logic signed [31:0] py, logic signed [31:0] pz,
                            logic [31:0] ids, logic [31:0] wts);
      int gap;
      if (tx_idle_en && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_palette_joint <= joint;
      req_palette_elem  <= elem;
      req_palette_value <= value;
      req_pos_x         <= px;
      req_pos_y         <= py;
      req_pos_z         <= pz;
      req_joint_ids     <= ids;
      req_joint_weights <= wts;
      do @(posedge clock); while (req_stall);
      // predict at acceptance
      if (func == FUNC_WRITE) begin
         write_count++;
         if (elem < ELEMS_PER_JOINT)
            palette_copy[joint * ELEMS_PER_JOINT + elem] = value;
      end else begin
         skin_pos_type e;
         e = blend_vertex(px, py, pz, ids, wts);
         vertex_count++;
         if (e.passed) pass_count++;
         expected_pos.insert(expected_pos.size(), e);
      end
      @(negedge clock);
   endtask

   task automatic write_elem(int joint, int elem, logic signed [31:0] value);
      send_beat(FUNC_WRITE, 8'(joint), 4'(elem), value, '0, '0, '0, '0, '0);
   endtask

   task automatic skin(logic signed [31:0] px, logic signed [31:0] py,
                       logic signed [31:0] pz, logic [31:0] ids, logic [31:0] wts);
      send_beat(FUNC_SKIN, '0, '0, '0, px, py, pz, ids, wts);
   endtask

   // wait for outstanding results, then settle before a register write
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_pos.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic set_joint_count(logic [8:0] n);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= n;
      joint_count = n;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [31:0] random_q();
      case ($urandom_range(0, 4))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         default: return $urandom;
      endcase
   endfunction

   // vertex with ids among the loaded joints, or at or past the palette count
   task automatic random_vertex(logic [8:0] n);
      logic [31:0] ids, wts;
      int hi;
      hi = (n == 0 || n > LOADED_JOINTS) ? LOADED_JOINTS - 1 : int'(n) - 1;
      for (int k = 0; k < SLOTS; k++) begin
         if (n < 256 && $urandom_range(0, 7) == 0)
            ids[8*k +: 8] = 8'($urandom_range(n, 255));
         else
            ids[8*k +: 8] = 8'($urandom_range(0, hi));
         case ($urandom_range(0, 5))
            0: wts[8*k +: 8] = 8'd0;
            1: wts[8*k +: 8] = 8'd255;
            default: wts[8*k +: 8] = 8'($urandom);
         endcase
      end
      skin(random_q(), random_q(), random_q(), ids, wts);
   endtask

   // every entry of the joints in use written once so no read of unwritten data
   task automatic test_palette_load();
      for (int j = 0; j < LOADED_JOINTS; j++)
         for (int e = 0; e < ELEMS_PER_JOINT; e++)
            write_elem(j, e, (j < 4) ? ((e % 5 == 0) ? 32'sh10000 : 32'sh0) : random_q());
   endtask

   // directed corners: pass-through, out-of-range, extremes
   task automatic test_directed();
      skin(32'sh7fffffff, 32'sh80000000, 32'sh12345, 32'h03020100, 32'h01010101);
      set_joint_count(9'd4);
      skin(32'sh10000, -32'sh20000, 32'sh30000, 32'h03020100, 32'h01010101);
      skin(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'h00000000, 32'h000000ff);
      skin(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'hffffffff, 32'hffffffff);
      skin(32'sh1, 32'sh2, 32'sh3, 32'h01020304, 32'h00000000);
      write_elem(1, 12, 32'sh7fffffff);
      write_elem(1, 15, 32'sh80000000);
      write_elem(4, 0, 32'sh7fffffff);
      write_elem(4, 5, 32'sh80000000);
      write_elem(4, 3, 32'sh7fffffff);
      set_joint_count(9'd256);
      skin(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'h04040404, 32'hff01ff01);
      skin(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'h17100004, 32'h80407f01);
      set_joint_count(9'd511);
      skin(32'sh40000, 32'sh50000, 32'sh60000, 32'h17161514, 32'hffffffff);
      set_joint_count(9'd0);
      skin(32'sh1, 32'sh1, 32'sh1, 32'h00000000, 32'hffffffff);
   endtask

   // long receiver hold while the sender keeps offering vertices
   task automatic test_backpressure();
      set_joint_count(9'd256);
      hold_cycles = 3000;
      repeat (12) random_vertex(9'd256);
      req_valid <= 1'b0;
      while (expected_pos.size() != 0) @(negedge clock);
   endtask

   // mixed random palette writes and vertices at one palette count
   task automatic test_random(int vertices, logic [8:0] n);
      int sent;
      set_joint_count(n);
      sent = 0;
      while (sent < vertices) begin
         if ($urandom_range(0, 4) == 0)
            write_elem($urandom_range(0, 255), $urandom_range(0, 15), random_q());
         else begin
            random_vertex(n);
            sent++;
         end
      end
   endtask

   initial begin
      req_valid = 1'b0; req_func = FUNC_WRITE; req_palette_joint = '0;
      req_palette_elem = '0; req_palette_value = '0; req_pos_x = '0; req_pos_y = '0;
      req_pos_z = '0; req_joint_ids = '0; req_joint_weights = '0;
      csr_write_enable = 1'b0; csr_write_data = '0;
      joint_count = '0; error_count = 0; cycle_count = 0; hold_cycles = 0;
      vertex_count = 0; pass_count = 0; write_count = 0;
      rx_idle_en = 1'b0; tx_idle_en = 1'b0;
      reset = 1'b1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_palette_load();
      test_directed();
      rx_idle_en = 1'b1; tx_idle_en = 1'b1;
      test_backpressure();
      test_random(120, 9'd256);
      test_random(100, 9'd17);
      test_random(80, 9'd1);
      test_random(90, 9'd300);
      rx_idle_en = 1'b0; tx_idle_en = 1'b0;
      test_random(60, 9'd200);

      drain();
      $display("run covered %0d vertices (%0d passed through) and %0d palette writes",
               vertex_count, pass_count, write_count);
      $display("palette counts 0, 1, 4, 17, 200, 256, 300 and 511, with long output hold");
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
